/* rtl/core/rfd_pkg.sv */
// shared constants and helpers for the refraction direction pipeline
`default_nettype none

package rfd_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int VEC_W         = 16;
   localparam int REQ_W         = 8 * VEC_W;
   localparam int RSP_W         = 3 * VEC_W;
   localparam int ROOT_IN_W     = 64;
   localparam int ROOT_W        = ROOT_IN_W / 2;
   localparam int MAG_W         = 64;
   localparam int MAG_BYTES     = MAG_W / 8;
   localparam int NORM_MSB      = 30;

   localparam logic [31:0] OUT_POS_LIM = 32'd32767;
   localparam logic [31:0] OUT_NEG_LIM = 32'd32768;

   // bit length of one byte, zero for zero
   function automatic logic [3:0] byte_len(input logic [7:0] b);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/refraction_direction.sv */
// refraction direction top level: snell refraction or mirror, then normalisation
//
// One word is accepted every cycle unless the pipeline holds, and one result word leaves per
// input word, in order. The path runs through the bit-per-stage index-ratio divider
// (16 + FRAC_BITS stages), two 32-stage square roots and the output dividers
// (FRAC_BITS + 2 stages). The whole pipeline holds while a result waits
// and rsp_tready is low; bubbles inside it hold as well and are not squeezed out.
// A zero-length result comes out as a zero vector; total_reflection rides on rsp_tuser.
`default_nettype none

module refraction_direction #(
   parameter int FRAC_BITS = rfd_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, index_from, index_to
   input  logic [rfd_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_x, out_y, out_z
   output logic [rfd_pkg::RSP_W-1:0] rsp_tdata,
   // total_reflection
   output logic                      rsp_tuser
);

   import rfd_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int EW     = F + 3;
   localparam int ETA_QW = VEC_W + F;
   localparam int CW     = 35 - F;
   localparam int CCW    = 2 * CW;
   localparam int ONE2W  = 2 * F + 2;
   localparam int DFW    = ((ONE2W > CCW) ? ONE2W : CCW) + 2;
   localparam int SW     = DFW - F;
   localparam int E2W    = F + 7;
   localparam int PRW    = E2W + 1 + SW;
   localparam int XW     = ((PRW > 64) ? PRW : 64) + 1;
   localparam int ACP    = EW + 1 + CW;
   localparam int ACW    = ACP - F;
   localparam int MW     = ((ACW > ROOT_W + 1) ? ACW : ROOT_W + 1) + 1;
   localparam int PW     = MW + VEC_W;
   localparam int AEW    = EW + 1 + VEC_W;
   localparam int RW0    = (PW > AEW) ? PW : AEW;
   localparam int RW     = ((RW0 > VEC_W + F + 1) ? RW0 : VEC_W + F + 1) + 1;
   localparam int NW     = ROOT_W + F;
   localparam int QB     = F + 2;
   localparam int EN_W   = 6 * VEC_W;
   localparam int AB_W   = NORM_MSB + 1;
   localparam logic [EW-1:0] ETA_MAX = {EW{1'b1}};

   typedef struct packed {
      logic                   tir;
      logic [EW-1:0]          eta;
      logic signed [CW-1:0]   c;
      logic signed [ACW-1:0]  etac;
      logic [EN_W-1:0]        en;
   } sq1_pay_type;

   typedef struct packed {
      logic            tir;
      logic            zero;
      logic [2:0]      sgn;
      logic [AB_W-1:0] ab2;
      logic [AB_W-1:0] ab1;
      logic [AB_W-1:0] ab0;
   } sq2_pay_type;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ratio of indices
   logic              d1_valid;
   logic [ETA_QW-1:0] d1_quo;
   logic [EN_W-1:0]   d1_pay;

   rfd_div #(.QUO_W(ETA_QW), .DEN_W(VEC_W), .PAY_W(EN_W)) u_eta_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_rem    ('0),
      .in_lo     ({req_tdata[6*VEC_W +: VEC_W], F'(0)}),
      .in_den    (req_tdata[7*VEC_W +: VEC_W]),
      .in_pay    (req_tdata[EN_W-1:0]),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_pay   (d1_pay)
   );

   function automatic logic signed [VEC_W-1:0] comp(input logic [EN_W-1:0] en, input int i);
      return $signed(en[VEC_W*i +: VEC_W]);
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [EW-1:0]          eta1_ff, eta2_ff, eta3_ff, eta4_ff, eta5_ff;
   logic [EN_W-1:0]        en1_ff, en2_ff, en3_ff, en4_ff, en5_ff;
   logic signed [31:0]     p1_ff [3];
   logic signed [CW-1:0]   c2_ff, c3_ff, c4_ff, c5_ff;
   logic [2*EW-1:0]        eq2_ff;
   logic signed [CCW-1:0]  cc3_ff;
   logic [E2W-1:0]         e2_3_ff, e2_4_ff;
   logic signed [ACP-1:0]  acp3_ff;
   logic signed [SW-1:0]   s4_ff;
   logic signed [ACW-1:0]  etac4_ff, etac5_ff;
   logic signed [PRW-1:0]  es5_ff;
   sq1_pay_type            pay6_ff;
   logic [ROOT_IN_W-1:0]   kin6_ff;

   logic signed [34:0]     dot_rnd;
   logic [2*EW-1:0]        eq_rnd;
   logic signed [DFW-1:0]  diff;
   logic signed [ACP-1:0]  ac_rnd;
   logic signed [XW-1:0]   es_x;
   logic signed [XW-1:0]   es_sat;
   logic signed [XW-1:0]   k_full;
   logic signed [XW-1:0]   sat_lim;
   logic [EW-1:0]          eta_in;

   always_comb begin
      eta_in  = (d1_quo > ETA_QW'(ETA_MAX)) ? ETA_MAX : d1_quo[EW-1:0];
      dot_rnd = 35'(p1_ff[0]) + 35'(p1_ff[1]) + 35'(p1_ff[2]) + (35'(1) <<< (F - 1));
      eq_rnd  = eq2_ff + ((2*EW)'(1) << (F - 1));
      diff    = (DFW'(1) <<< (2 * F)) - DFW'(cc3_ff) + (DFW'(1) <<< (F - 1));
      ac_rnd  = acp3_ff + (ACP'(1) <<< (F - 1));
      sat_lim = XW'(1) <<< 62;
      es_x    = XW'(es5_ff);
      if (es_x > sat_lim) begin
         es_sat = sat_lim;
      end else if (es_x < -sat_lim) begin
         es_sat = -sat_lim;
      end else begin
         es_sat = es_x;
      end
      k_full = (XW'(1) <<< (2 * F)) - es_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= d1_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // dot products, clamped ratio
         eta1_ff <= eta_in;
         en1_ff  <= d1_pay;
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= 32'(comp(d1_pay, i) * comp(d1_pay, i + 3));
         end
         // c and eta squared
         eta2_ff <= eta1_ff;
         en2_ff  <= en1_ff;
         c2_ff   <= CW'(dot_rnd >>> F);
         eq2_ff  <= (2*EW)'(eta1_ff * eta1_ff);
         // c squared, eta c
         eta3_ff <= eta2_ff;
         en3_ff  <= en2_ff;
         c3_ff   <= c2_ff;
         cc3_ff  <= CCW'(c2_ff * c2_ff);
         e2_3_ff <= E2W'(eq_rnd >> F);
         acp3_ff <= ACP'($signed({1'b0, eta2_ff}) * c2_ff);
         // s and rounded eta c
         eta4_ff  <= eta3_ff;
         en4_ff   <= en3_ff;
         c4_ff    <= c3_ff;
         e2_4_ff  <= e2_3_ff;
         s4_ff    <= SW'(diff >>> F);
         etac4_ff <= ACW'(ac_rnd >>> F);
         // eta squared times s
         eta5_ff  <= eta4_ff;
         en5_ff   <= en4_ff;
         c5_ff    <= c4_ff;
         etac5_ff <= etac4_ff;
         es5_ff   <= PRW'($signed({1'b0, e2_4_ff}) * s4_ff);
         // k and reflection decision
         pay6_ff.tir  <= k_full[XW-1];
         pay6_ff.eta  <= eta5_ff;
         pay6_ff.c    <= c5_ff;
         pay6_ff.etac <= etac5_ff;
         pay6_ff.en   <= en5_ff;
         kin6_ff      <= k_full[XW-1] ? '0 : k_full[ROOT_IN_W-1:0];
      end
   end

   // square root of k
   logic               q1_valid;
   logic [ROOT_W-1:0]  q1_root;
   logic [$bits(sq1_pay_type)-1:0] q1_bits;
   sq1_pay_type        q1_pay;

   rfd_sqrt #(.PAY_W($bits(sq1_pay_type))) u_k_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v6_ff),
      .in_val    (kin6_ff),
      .in_pay    (pay6_ff),
      .out_valid (q1_valid),
      .out_root  (q1_root),
      .out_pay   (q1_bits)
   );
   assign q1_pay = sq1_pay_type'(q1_bits);

   logic v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff;
   logic tir7_ff, tir8_ff, tir9_ff, tir10_ff, tir11_ff, tir12_ff, tir13_ff, tir14_ff;
   logic [EW-1:0]            eta7_ff;
   logic [EN_W-1:0]          en7_ff;
   logic signed [MW-1:0]     coef7_ff;
   logic signed [PW-1:0]     prod8_ff [3];
   logic signed [RW-1:0]     ae8_ff [3];
   logic signed [RW-1:0]     r9_ff [3];
   logic signed [RW-1:0]     r10_ff [3];
   logic signed [RW-1:0]     r11_ff [3];
   logic signed [RW-1:0]     r12_ff [3];
   logic [MAG_W-1:0]         mag10_ff;
   logic                     zero11_ff, zero12_ff, zero13_ff, zero14_ff;
   logic [2:0]               idx11_ff;
   logic [7:0]               byte11_ff;
   logic [6:0]               bl12_ff;
   logic signed [31:0]       sn13_ff [3];
   logic [ROOT_IN_W-1:0]     sq14_ff [3];
   logic [AB_W-1:0]          abs14_ff [3];
   logic [2:0]               sgn14_ff;
   sq2_pay_type              pay15_ff;
   logic [ROOT_IN_W-1:0]     len2_15_ff;

   logic [RW-1:0]            abs_r [3];
   logic [2:0]               idx_in;
   logic [7:0]               byte_in;
   logic signed [63:0]       r_wide [3];
   logic signed [63:0]       r_norm [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_r[i] = r9_ff[i][RW-1] ? RW'(-r9_ff[i]) : RW'(r9_ff[i]);
      end
      idx_in  = '0;
      byte_in = '0;
      for (int b = 0; b < MAG_BYTES; b++) begin
         if (mag10_ff[8*b +: 8] != '0) begin
            idx_in  = 3'(b);
            byte_in = mag10_ff[8*b +: 8];
         end
      end
      for (int i = 0; i < 3; i++) begin
         r_wide[i] = 64'(r12_ff[i]);
         if (bl12_ff > 7'(NORM_MSB)) begin
            r_norm[i] = r_wide[i] >>> 7'(bl12_ff - 7'(NORM_MSB));
         end else begin
            r_norm[i] = r_wide[i] <<< 7'(7'(NORM_MSB) - bl12_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         v15_ff <= 1'b0;
      end else if (adv) begin
         v7_ff  <= q1_valid;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
         v15_ff <= v14_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // normal coefficient
         tir7_ff  <= q1_pay.tir;
         eta7_ff  <= q1_pay.eta;
         en7_ff   <= q1_pay.en;
         coef7_ff <= q1_pay.tir ? (MW'(q1_pay.c) <<< 1)
                                : MW'(q1_pay.etac) + MW'($signed({1'b0, q1_root}));
         // products per lane
         tir8_ff <= tir7_ff;
         for (int i = 0; i < 3; i++) begin
            prod8_ff[i] <= PW'(coef7_ff * comp(en7_ff, i + 3));
            ae8_ff[i]   <= tir7_ff ? (RW'(comp(en7_ff, i)) <<< F)
                                   : RW'($signed({1'b0, eta7_ff}) * comp(en7_ff, i));
         end
         // unnormalised direction
         tir9_ff <= tir8_ff;
         for (int i = 0; i < 3; i++) begin
            r9_ff[i] <= ae8_ff[i] - RW'(prod8_ff[i]);
         end
         // largest magnitude bits
         tir10_ff <= tir9_ff;
         r10_ff   <= r9_ff;
         mag10_ff <= MAG_W'(abs_r[0] | abs_r[1] | abs_r[2]);
         // top nonzero byte
         tir11_ff  <= tir10_ff;
         r11_ff    <= r10_ff;
         zero11_ff <= mag10_ff == '0;
         idx11_ff  <= idx_in;
         byte11_ff <= byte_in;
         // bit length
         tir12_ff  <= tir11_ff;
         r12_ff    <= r11_ff;
         zero12_ff <= zero11_ff;
         bl12_ff   <= 7'({idx11_ff, 3'b000}) + 7'(byte_len(byte11_ff));
         // scale to a fixed magnitude
         tir13_ff  <= tir12_ff;
         zero13_ff <= zero12_ff;
         for (int i = 0; i < 3; i++) begin
            sn13_ff[i] <= r_norm[i][31:0];
         end
         // squares
         tir14_ff  <= tir13_ff;
         zero14_ff <= zero13_ff;
         for (int i = 0; i < 3; i++) begin
            sq14_ff[i]  <= 64'(sn13_ff[i] * sn13_ff[i]);
            abs14_ff[i] <= sn13_ff[i][31] ? AB_W'(-sn13_ff[i]) : AB_W'(sn13_ff[i]);
            sgn14_ff[i] <= sn13_ff[i][31];
         end
         // squared length
         pay15_ff.tir  <= tir14_ff;
         pay15_ff.zero <= zero14_ff;
         pay15_ff.sgn  <= sgn14_ff;
         pay15_ff.ab0  <= abs14_ff[0];
         pay15_ff.ab1  <= abs14_ff[1];
         pay15_ff.ab2  <= abs14_ff[2];
         len2_15_ff    <= sq14_ff[0] + sq14_ff[1] + sq14_ff[2];
      end
   end

   // length
   logic               q2_valid;
   logic [ROOT_W-1:0]  q2_root;
   logic [$bits(sq2_pay_type)-1:0] q2_bits;
   sq2_pay_type        q2_pay;

   rfd_sqrt #(.PAY_W($bits(sq2_pay_type))) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v15_ff),
      .in_val    (len2_15_ff),
      .in_pay    (pay15_ff),
      .out_valid (q2_valid),
      .out_root  (q2_root),
      .out_pay   (q2_bits)
   );
   assign q2_pay = sq2_pay_type'(q2_bits);

   logic              v16_ff;
   logic              tir16_ff;
   logic              zero16_ff;
   logic [2:0]        sgn16_ff;
   logic [NW-1:0]     num16_ff [3];
   logic [ROOT_W-1:0] den16_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v16_ff <= 1'b0;
      end else if (adv) begin
         v16_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tir16_ff    <= q2_pay.tir;
         zero16_ff   <= q2_pay.zero;
         sgn16_ff    <= q2_pay.sgn;
         num16_ff[0] <= (NW'(q2_pay.ab0) << (F + 1)) + NW'(q2_root);
         num16_ff[1] <= (NW'(q2_pay.ab1) << (F + 1)) + NW'(q2_root);
         num16_ff[2] <= (NW'(q2_pay.ab2) << (F + 1)) + NW'(q2_root);
         den16_ff    <= {q2_root[ROOT_W-2:0], 1'b0};
      end
   end

   // rounded division by the length, one lane per component
   logic          d3_valid [3];
   logic [QB-1:0] d3_quo [3];
   logic [2:0]    d3_pay [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rfd_div #(.QUO_W(QB), .DEN_W(ROOT_W), .PAY_W(3)) u_out_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (v16_ff),
         .in_rem    (ROOT_W'(num16_ff[i][NW-1:QB])),
         .in_lo     (num16_ff[i][QB-1:0]),
         .in_den    (den16_ff),
         .in_pay    ({tir16_ff, zero16_ff, sgn16_ff[i]}),
         .out_valid (d3_valid[i]),
         .out_quo   (d3_quo[i]),
         .out_pay   (d3_pay[i])
      );
   end

   logic [VEC_W-1:0] out_in [3];
   logic [31:0]      q_wide [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_wide[i] = 32'(d3_quo[i]);
         if (d3_pay[0][1]) begin
            out_in[i] = '0;
         end else if (d3_pay[i][0]) begin
            out_in[i] = (q_wide[i] > OUT_NEG_LIM) ? VEC_W'(OUT_NEG_LIM) : VEC_W'(-q_wide[i]);
         end else begin
            out_in[i] = (q_wide[i] > OUT_POS_LIM) ? VEC_W'(OUT_POS_LIM) : q_wide[i][VEC_W-1:0];
         end
      end
   end

   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d3_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {out_in[2], out_in[1], out_in[0]};
         rsp_tir_ff  <= d3_pay[0][2];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_tir_ff;

`ifndef SYNTH
   a_lanes_valid: assert property (@(posedge clock) disable iff (reset)
      (d3_valid[1] == d3_valid[0]) && (d3_valid[2] == d3_valid[0]))
      else $error("output divider lanes out of step");

   a_lanes_flags: assert property (@(posedge clock) disable iff (reset)
      d3_valid[0] |-> (d3_pay[1][2:1] == d3_pay[0][2:1]) && (d3_pay[2][2:1] == d3_pay[0][2:1]))
      else $error("output divider lanes carry different flags");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      q2_valid && !q2_pay.zero |-> !q2_root[ROOT_W-1] && (q2_root[ROOT_W-2 -: 2] != 2'b00))
      else $error("length of scaled vector out of range");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      d3_valid[0] && !d3_pay[0][1] |-> q_wide[0] <= (32'd1 << F))
      else $error("normalised component above one");
`endif

endmodule

`default_nettype wire

/* rtl/core/rfd_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module rfd_div #(
   parameter int QUO_W = 16,
   parameter int DEN_W = 16,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [QUO_W-1:0] in_lo,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [PAY_W-1:0] out_pay
);

   logic             vld_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] lo_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [PAY_W-1:0] pay_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic             vld_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [QUO_W-1:0] lo_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [DEN_W-1:0] den_prev;
      logic [PAY_W-1:0] pay_prev;
      logic [DEN_W:0]   trial;
      logic             fits;
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] lo_in;
      logic [QUO_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = in_rem;
         assign lo_prev  = in_lo;
         assign quo_prev = '0;
         assign den_prev = in_den;
         assign pay_prev = in_pay;
      end else begin : g_next
         assign vld_prev = vld_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign lo_prev  = lo_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign pay_prev = pay_ff[j-1];
      end

      assign trial  = {rem_prev, lo_prev[QUO_W-1]};
      assign fits   = trial >= {1'b0, den_prev};
      assign rem_in = fits ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
      assign lo_in  = lo_prev << 1;
      assign quo_in = {quo_prev[QUO_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_in;
            lo_ff[j]  <= lo_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_prev;
            pay_ff[j] <= pay_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_pay   = pay_ff[QUO_W-1];

endmodule

`default_nettype wire

/* rtl/core/rfd_sqrt.sv */
// pipelined integer square root, one root bit per stage
`default_nettype none

module rfd_sqrt #(
   parameter int PAY_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [rfd_pkg::ROOT_IN_W-1:0] in_val,
   input  logic [PAY_W-1:0]              in_pay,
   output logic                          out_valid,
   output logic [rfd_pkg::ROOT_W-1:0]    out_root,
   output logic [PAY_W-1:0]              out_pay
);

   import rfd_pkg::*;

   logic                 vld_ff [ROOT_W];
   logic [ROOT_IN_W-1:0] val_ff [ROOT_W];
   logic [ROOT_IN_W-1:0] res_ff [ROOT_W];
   logic [PAY_W-1:0]     pay_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam logic [ROOT_IN_W-1:0] STEP = ROOT_IN_W'(1) << (ROOT_IN_W - 2 - 2 * j);
      logic                 vld_prev;
      logic [ROOT_IN_W-1:0] val_prev;
      logic [ROOT_IN_W-1:0] res_prev;
      logic [PAY_W-1:0]     pay_prev;
      logic [ROOT_IN_W-1:0] trial;
      logic                 fits;
      logic [ROOT_IN_W-1:0] val_in;
      logic [ROOT_IN_W-1:0] res_in;

      if (j == 0) begin : g_first
         assign vld_prev = in_valid;
         assign val_prev = in_val;
         assign res_prev = '0;
         assign pay_prev = in_pay;
      end else begin : g_next
         assign vld_prev = vld_ff[j-1];
         assign val_prev = val_ff[j-1];
         assign res_prev = res_ff[j-1];
         assign pay_prev = pay_ff[j-1];
      end

      assign trial  = res_prev + STEP;
      assign fits   = val_prev >= trial;
      assign val_in = fits ? val_prev - trial : val_prev;
      assign res_in = fits ? (res_prev >> 1) + STEP : res_prev >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            val_ff[j] <= val_in;
            res_ff[j] <= res_in;
            pay_ff[j] <= pay_prev;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = res_ff[ROOT_W-1][ROOT_W-1:0];
   assign out_pay   = pay_ff[ROOT_W-1];

endmodule

`default_nettype wire
